/* design/vrt_pkg.sv */
`default_nettype none
package vrt_pkg;

  // Grid and fixed-point formats.
  localparam int MAX_GRID  = 16;
  localparam int FRAC_BITS = 16;
  localparam int GRID_W    = 5;
  localparam int CELL_W    = 4;
  localparam int POS_W     = 25;
  localparam int DIR_W     = 18;
  localparam int T_W       = 32;
  localparam int LIM_W     = GRID_W + FRAC_BITS;
  localparam int NUM_W     = POS_W + 1;
  localparam int PROD_W    = NUM_W + DIR_W;
  localparam int DIVN_W    = PROD_W - 2;
  localparam int DIVD_W    = DIR_W;
  localparam int DIST_W    = FRAC_BITS + 1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       load_in;
    logic       init_inside;
    logic       clip_begin;
    logic       mul;
    logic       div_clip;
    logic       fix;
    logic       place_face;
    logic       div_delta;
    logic       div_next;
    logic       store_delta;
    logic       store_next;
    logic       sat_axis;
    logic       emit_step;
    logic       emit_miss;
    logic [1:0] ax;
    logic [1:0] ob;
  } vrt_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic [2:0] outside;
    logic       away;
    logic       ok;
    logic       div_done;
    logic [2:0] dir_zero;
    logic       out_free;
    logic       step_exit;
  } vrt_stat_t;

endpackage
`default_nettype wire

/* design/voxel_ray_traversal_unit.sv */
// Voxel ray traversal over a cubic grid of grid_size^3 cells.
// Input channel (in_valid_i/in_ready_o): one ray per transfer, origin and
// direction in signed fixed point with 16 fraction bits. A new ray is taken
// only after every cell of the previous ray has been put in the output register.
// Output channel (out_valid_o/out_ready_i): one visited cell per transfer in
// visiting order; last_o marks the final cell. A ray that misses the grid
// gives a single transfer with hit_o low and last_o high.
// Configuration channel (cfg_valid_i/cfg_ready_o): writes grid_size, always
// ready; write it only while no ray is in flight.
// Divisions: every division runs on one bit-serial divider at one quotient
// bit per cycle. An inside ray needs up to six divisions before its first
// cell; a clipped ray adds two divisions per outside axis tried. After that
// one cell comes per cycle while the receiver keeps taking them. A missing
// ray aimed away needs no division and goes from the check straight to its
// miss answer.
// Reset clears the controller and output valid and sets grid_size to 16.
// When the receiver stalls, the held result stays in the output register
// and traversal pauses until the transfer completes.
`default_nettype none
module voxel_ray_traversal_unit (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_ready_o,
  input  wire logic signed [vrt_pkg::POS_W-1:0] origin_x_i,
  input  wire logic signed [vrt_pkg::POS_W-1:0] origin_y_i,
  input  wire logic signed [vrt_pkg::POS_W-1:0] origin_z_i,
  input  wire logic signed [vrt_pkg::DIR_W-1:0] dir_x_i,
  input  wire logic signed [vrt_pkg::DIR_W-1:0] dir_y_i,
  input  wire logic signed [vrt_pkg::DIR_W-1:0] dir_z_i,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [vrt_pkg::GRID_W-1:0]       grid_size_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [vrt_pkg::CELL_W-1:0]            cell_x_o,
  output logic [vrt_pkg::CELL_W-1:0]            cell_y_o,
  output logic [vrt_pkg::CELL_W-1:0]            cell_z_o,
  output logic                                  hit_o,
  output logic                                  last_o
);
  import vrt_pkg::*;

  vrt_cmd_t  cmd;
  vrt_stat_t stat;

  // The configuration register takes a write in any cycle.
  assign cfg_ready_o = 1'b1;

  vrt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  vrt_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .origin_x_i  (origin_x_i),
    .origin_y_i  (origin_y_i),
    .origin_z_i  (origin_z_i),
    .dir_x_i     (dir_x_i),
    .dir_y_i     (dir_y_i),
    .dir_z_i     (dir_z_i),
    .cfg_valid_i (cfg_valid_i),
    .grid_size_i (grid_size_i),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cell_x_o    (cell_x_o),
    .cell_y_o    (cell_y_o),
    .cell_z_o    (cell_z_o),
    .hit_o       (hit_o),
    .last_o      (last_o)
  );

endmodule
`default_nettype wire

/* design/vrt_div.sv */
`default_nettype none
module vrt_div (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  input  wire logic [vrt_pkg::DIVN_W-1:0] dividend_i,
  input  wire logic [vrt_pkg::DIVD_W-1:0] divisor_i,
  output logic                            done_o,
  output logic [vrt_pkg::DIVN_W-1:0]      quotient_o,
  output logic                            rem_nz_o
);
  import vrt_pkg::*;

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic               run_q, done_q;
  logic [CNT_W-1:0]   cnt_q;
  logic [DIVD_W:0]    rem_q, shifted, trial;
  logic [DIVN_W-1:0]  quo_q;
  logic [DIVD_W-1:0]  dvs_q;
  logic               take;

  // One quotient bit per cycle, restoring form.
  always_comb begin
    shifted = {rem_q[DIVD_W-1:0], quo_q[DIVN_W-1]};
    trial   = shifted - {1'b0, dvs_q};
    take    = shifted >= {1'b0, dvs_q};
  end

  // Control of the iteration count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= CNT_W'(DIVN_W);
      end else if (run_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Partial remainder and quotient shift register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (run_q) begin
      rem_q <= take ? trial : shifted;
      quo_q <= {quo_q[DIVN_W-2:0], take};
    end
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;
  assign rem_nz_o   = rem_q != '0;

endmodule
`default_nettype wire

/* design/vrt_ctrl.sv */
`default_nettype none
module vrt_ctrl (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire vrt_pkg::vrt_stat_t stat_i,
  output vrt_pkg::vrt_cmd_t       cmd_o
);
  import vrt_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_CHECK, S_AXIS, S_MUL, S_DIVGO, S_DIVW, S_FIX, S_DECIDE,
    S_RCP, S_RDW, S_RNGO, S_RNW, S_STEP, S_MISS
  } state_e;

  state_e     state_q, state_d;
  logic [1:0] ax_q, ax_d, ob_q, ob_d;
  logic [1:0] oth0, oth1;

  // The two axes other than the one being clipped.
  assign oth0 = (ax_q == 2'd0) ? 2'd1 : 2'd0;
  assign oth1 = (ax_q == 2'd2) ? 2'd1 : 2'd2;

  // Next state and commands.
  always_comb begin
    state_d = state_q;
    ax_d    = ax_q;
    ob_d    = ob_q;
    cmd_o   = '0;
    cmd_o.ax = ax_q;
    cmd_o.ob = ob_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        ax_d = 2'd0;
        if (stat_i.outside == 3'b000) begin
          cmd_o.init_inside = 1'b1;
          state_d = S_RCP;
        end else if (stat_i.away) begin
          state_d = S_MISS;
        end else begin
          state_d = S_AXIS;
        end
      end
      S_AXIS: begin
        if (ax_q == 2'd3) begin
          state_d = S_MISS;
        end else if (!stat_i.outside[ax_q]) begin
          ax_d = ax_q + 2'd1;
        end else begin
          cmd_o.clip_begin = 1'b1;
          ob_d = oth0;
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_DIVGO;
      end
      S_DIVGO: begin
        cmd_o.div_clip = 1'b1;
        state_d = S_DIVW;
      end
      S_DIVW: begin
        if (stat_i.div_done) state_d = S_FIX;
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        if (ob_q == oth1) begin
          state_d = S_DECIDE;
        end else begin
          ob_d = oth1;
          state_d = S_MUL;
        end
      end
      S_DECIDE: begin
        if (stat_i.ok) begin
          cmd_o.place_face = 1'b1;
          ax_d = 2'd0;
          state_d = S_RCP;
        end else begin
          ax_d = ax_q + 2'd1;
          state_d = S_AXIS;
        end
      end
      S_RCP: begin
        if (ax_q == 2'd3) begin
          state_d = S_STEP;
        end else if (stat_i.dir_zero[ax_q]) begin
          cmd_o.sat_axis = 1'b1;
          ax_d = ax_q + 2'd1;
        end else begin
          cmd_o.div_delta = 1'b1;
          state_d = S_RDW;
        end
      end
      S_RDW: begin
        if (stat_i.div_done) begin
          cmd_o.store_delta = 1'b1;
          state_d = S_RNGO;
        end
      end
      S_RNGO: begin
        cmd_o.div_next = 1'b1;
        state_d = S_RNW;
      end
      S_RNW: begin
        if (stat_i.div_done) begin
          cmd_o.store_next = 1'b1;
          ax_d = ax_q + 2'd1;
          state_d = S_RCP;
        end
      end
      S_STEP: begin
        if (stat_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (stat_i.step_exit) state_d = S_IDLE;
        end
      end
      S_MISS: begin
        if (stat_i.out_free) begin
          cmd_o.emit_miss = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State and axis counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ax_q    <= 2'd0;
      ob_q    <= 2'd0;
    end else begin
      state_q <= state_d;
      ax_q    <= ax_d;
      ob_q    <= ob_d;
    end
  end

  assign in_ready_o = state_q == S_IDLE;

endmodule
`default_nettype wire

/* design/vrt_dp.sv */
`default_nettype none
module vrt_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic signed [vrt_pkg::POS_W-1:0] origin_x_i,
  input  wire logic signed [vrt_pkg::POS_W-1:0] origin_y_i,
  input  wire logic signed [vrt_pkg::POS_W-1:0] origin_z_i,
  input  wire logic signed [vrt_pkg::DIR_W-1:0] dir_x_i,
  input  wire logic signed [vrt_pkg::DIR_W-1:0] dir_y_i,
  input  wire logic signed [vrt_pkg::DIR_W-1:0] dir_z_i,
  input  wire logic                             cfg_valid_i,
  input  wire logic [vrt_pkg::GRID_W-1:0]       grid_size_i,
  input  wire vrt_pkg::vrt_cmd_t                cmd_i,
  output vrt_pkg::vrt_stat_t                    stat_o,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic [vrt_pkg::CELL_W-1:0]            cell_x_o,
  output logic [vrt_pkg::CELL_W-1:0]            cell_y_o,
  output logic [vrt_pkg::CELL_W-1:0]            cell_z_o,
  output logic                                  hit_o,
  output logic                                  last_o
);
  import vrt_pkg::*;

  localparam logic [T_W-1:0]    T_SAT = '1;
  localparam logic [DIST_W-1:0] ONE   = DIST_W'(1) << FRAC_BITS;

  logic [GRID_W-1:0]       gsz_q, g, gm1;
  logic [LIM_W-1:0]        lim;
  logic signed [POS_W-1:0] lim_s;
  logic signed [POS_W-1:0] o_q [3];
  logic signed [DIR_W-1:0] d_q [3];
  logic [LIM_W-1:0]        p_q [3];
  logic [CELL_W-1:0]       cell_q [3];
  logic [T_W-1:0]          nt_q [3], dt_q [3];
  logic                    ok_q;
  logic signed [PROD_W-1:0] prod_q;
  logic                    ov_q, hit_q, last_q;
  logic [CELL_W-1:0]       ox_q, oy_q, oz_q;

  // Configuration register, clamped to 1..MAX_GRID on use.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gsz_q <= GRID_W'(MAX_GRID);
    end else if (cfg_valid_i) begin
      gsz_q <= grid_size_i;
    end
  end

  always_comb begin
    if (gsz_q == '0) g = GRID_W'(1);
    else if (gsz_q > GRID_W'(MAX_GRID)) g = GRID_W'(MAX_GRID);
    else g = gsz_q;
    gm1   = g - GRID_W'(1);
    lim   = LIM_W'(g) << FRAC_BITS;
    lim_s = POS_W'(lim);
  end

  // Inside and aim-away tests per axis.
  logic [2:0] outside, away_v, dzero;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      outside[a] = (o_q[a] < 0) || (o_q[a] > lim_s);
      away_v[a]  = ((o_q[a] < 0) && (d_q[a] <= 0)) ||
                   ((o_q[a] > lim_s) && (d_q[a] >= 0));
      dzero[a]   = d_q[a] == '0;
    end
  end

  // Per-axis selections for the axis and other-axis indexes.
  logic signed [POS_W-1:0] o_ax, o_ob;
  logic signed [DIR_W-1:0] d_ax, d_ob;
  logic [LIM_W-1:0]        p_ax;
  always_comb begin
    case (cmd_i.ax)
      2'd0: begin o_ax = o_q[0]; d_ax = d_q[0]; p_ax = p_q[0]; end
      2'd1: begin o_ax = o_q[1]; d_ax = d_q[1]; p_ax = p_q[1]; end
      2'd2: begin o_ax = o_q[2]; d_ax = d_q[2]; p_ax = p_q[2]; end
      default: begin o_ax = '0; d_ax = '0; p_ax = '0; end
    endcase
    case (cmd_i.ob)
      2'd0: begin o_ob = o_q[0]; d_ob = d_q[0]; end
      2'd1: begin o_ob = o_q[1]; d_ob = d_q[1]; end
      2'd2: begin o_ob = o_q[2]; d_ob = d_q[2]; end
      default: begin o_ob = '0; d_ob = '0; end
    endcase
  end

  // Distance to the clip face and the product with the other direction.
  logic signed [NUM_W-1:0] num;
  logic                    ax_low;
  assign ax_low = o_ax < 0;
  assign num = ax_low ? -NUM_W'(o_ax) : (NUM_W'(lim) - NUM_W'(o_ax));

  // Shared divider operands.
  logic [DIVD_W-1:0]  dmag;
  logic [PROD_W-1:0]  pmag;
  logic [DIVN_W-1:0]  dividend;
  logic [DIST_W-1:0]  gap;
  logic [FRAC_BITS-1:0] frac;
  logic               div_start, div_done, rem_nz;
  logic [DIVN_W-1:0]  quo;
  logic [T_W-1:0]     quo_sat;

  always_comb begin
    dmag = d_ax[DIR_W-1] ? DIVD_W'(-d_ax) : DIVD_W'(d_ax);
    pmag = prod_q[PROD_W-1] ? PROD_W'(-prod_q) : PROD_W'(prod_q);
    frac = p_ax[FRAC_BITS-1:0];
    if (d_ax[DIR_W-1]) gap = (frac == '0) ? ONE : DIST_W'(frac);
    else gap = ONE - DIST_W'(frac);
    if (cmd_i.div_clip) dividend = pmag[DIVN_W-1:0];
    else if (cmd_i.div_delta) dividend = DIVN_W'(1) << (2 * FRAC_BITS);
    else dividend = DIVN_W'(gap) << FRAC_BITS;
    div_start = cmd_i.div_clip | cmd_i.div_delta | cmd_i.div_next;
    quo_sat = (quo[DIVN_W-1:T_W] != '0) ? T_SAT : quo[T_W-1:0];
  end

  vrt_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dividend),
    .divisor_i  (dmag),
    .done_o     (div_done),
    .quotient_o (quo),
    .rem_nz_o   (rem_nz)
  );

  // Floor-rounded clip coordinate on the other axis.
  logic                     neg;
  logic signed [PROD_W-1:0] qe, res, sum;
  logic                     sum_ok;
  always_comb begin
    neg    = prod_q[PROD_W-1] ^ d_ax[DIR_W-1];
    qe     = PROD_W'(quo) + PROD_W'(rem_nz);
    res    = neg ? -qe : PROD_W'(quo);
    sum    = PROD_W'(o_ob) + res;
    sum_ok = !sum[PROD_W-1] && (sum < PROD_W'(lim));
  end

  // Traversal step: pick the axis with the smallest t and test the exit.
  logic [1:0]        sel;
  logic [CELL_W-1:0] cur;
  logic              sneg, exit_s;
  logic [T_W:0]      tsum;
  logic [T_W-1:0]    tnew;
  always_comb begin
    if (nt_q[0] <= nt_q[1] && nt_q[0] <= nt_q[2]) sel = 2'd0;
    else if (nt_q[1] <= nt_q[2]) sel = 2'd1;
    else sel = 2'd2;
    case (sel)
      2'd0: begin cur = cell_q[0]; sneg = d_q[0][DIR_W-1];
                  tsum = {1'b0, nt_q[0]} + {1'b0, dt_q[0]}; end
      2'd1: begin cur = cell_q[1]; sneg = d_q[1][DIR_W-1];
                  tsum = {1'b0, nt_q[1]} + {1'b0, dt_q[1]}; end
      default: begin cur = cell_q[2]; sneg = d_q[2][DIR_W-1];
                  tsum = {1'b0, nt_q[2]} + {1'b0, dt_q[2]}; end
    endcase
    exit_s = sneg ? (cur == '0) : ((GRID_W'(cur) + GRID_W'(1)) >= g);
    tnew   = tsum[T_W] ? T_SAT : tsum[T_W-1:0];
  end

  // Ray registers, clip results and traversal state.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      o_q[0] <= origin_x_i;
      o_q[1] <= origin_y_i;
      o_q[2] <= origin_z_i;
      d_q[0] <= dir_x_i;
      d_q[1] <= dir_y_i;
      d_q[2] <= dir_z_i;
    end
    if (cmd_i.init_inside) begin
      for (int a = 0; a < 3; a++) begin
        p_q[a] <= o_q[a][LIM_W-1:0];
        cell_q[a] <= (o_q[a][LIM_W-1:FRAC_BITS] > gm1) ? gm1[CELL_W-1:0]
                                                       : o_q[a][FRAC_BITS+CELL_W-1:FRAC_BITS];
      end
    end
    if (cmd_i.clip_begin) ok_q <= 1'b1;
    if (cmd_i.mul) prod_q <= PROD_W'(num) * PROD_W'(d_ob);
    if (cmd_i.fix) begin
      if (!sum_ok) ok_q <= 1'b0;
      p_q[cmd_i.ob] <= sum[LIM_W-1:0];
    end
    if (cmd_i.place_face) begin
      for (int a = 0; a < 3; a++) begin
        if (a == int'(cmd_i.ax)) begin
          p_q[a]    <= ax_low ? '0 : lim;
          cell_q[a] <= d_q[a][DIR_W-1] ? gm1[CELL_W-1:0] : '0;
        end else begin
          cell_q[a] <= p_q[a][FRAC_BITS+CELL_W-1:FRAC_BITS];
        end
      end
    end
    if (cmd_i.sat_axis) begin
      nt_q[cmd_i.ax] <= T_SAT;
      dt_q[cmd_i.ax] <= T_SAT;
    end
    if (cmd_i.store_delta) dt_q[cmd_i.ax] <= quo_sat;
    if (cmd_i.store_next) nt_q[cmd_i.ax] <= quo_sat;
    if (cmd_i.emit_step && !exit_s) begin
      cell_q[sel] <= sneg ? cur - CELL_W'(1) : cur + CELL_W'(1);
      nt_q[sel]   <= tnew;
    end
  end

  // Output register: filled on emit, drained on transfer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (cmd_i.emit_step || cmd_i.emit_miss) begin
      ov_q <= 1'b1;
    end else if (out_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      ox_q   <= cell_q[0];
      oy_q   <= cell_q[1];
      oz_q   <= cell_q[2];
      hit_q  <= 1'b1;
      last_q <= exit_s;
    end else if (cmd_i.emit_miss) begin
      ox_q   <= '0;
      oy_q   <= '0;
      oz_q   <= '0;
      hit_q  <= 1'b0;
      last_q <= 1'b1;
    end
  end

  assign out_valid_o = ov_q;
  assign cell_x_o    = ox_q;
  assign cell_y_o    = oy_q;
  assign cell_z_o    = oz_q;
  assign hit_o       = hit_q;
  assign last_o      = last_q;

  // Status back to the controller.
  always_comb begin
    stat_o.outside   = outside;
    stat_o.away      = |away_v;
    stat_o.ok        = ok_q;
    stat_o.div_done  = div_done;
    stat_o.dir_zero  = dzero;
    stat_o.out_free  = !ov_q || out_ready_i;
    stat_o.step_exit = exit_s;
  end

endmodule
`default_nettype wire
